FILE: hw/rtl/bdrm_pkg.sv
// Package with the shared types, constants and defaults of the block range minimum unit.
`default_nettype none

package bdrm_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  localparam int DEF_NUM_ELEMENTS = 1024;
  localparam int DEF_BLOCK_SIZE   = 32;

  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DL1,
    ST_DL2,
    ST_DL3,
    ST_DH1,
    ST_DH2,
    ST_DH3,
    ST_WR_ELEM,
    ST_SET_A,
    ST_SCAN_A,
    ST_SET_B,
    ST_SCAN_B,
    ST_SET_C,
    ST_SCAN_C,
    ST_DRAIN,
    ST_WR_BLK,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_WBLK,
    LD_A,
    LD_B,
    LD_C
  } ld_sel_t;

  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    elem_we;
    logic    blk_we;
    logic    div_sel;
    logic    div_ld_lo;
    logic    div_ld_hi;
    logic    rd_elem;
    logic    rd_blk;
    logic    out_load;
    ld_sel_t ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic lo_ok;
    logic empty;
    logic same_blk;
    logic mid_nonempty;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdrm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bdrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bdrm_dp.sv
// Datapath: input and output registers, block divider, scan pointer, running minimum and stores.
`default_nettype none

module bdrm_dp #(
  parameter int NUM_ELEMENTS = bdrm_pkg::DEF_NUM_ELEMENTS,
  parameter int BLOCK_SIZE   = bdrm_pkg::DEF_BLOCK_SIZE
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bdrm_pkg::ctl_cmd_t                  cmd,
  output bdrm_pkg::dp_status_t                     status,
  input  wire logic                                in_cmd,
  input  wire logic        [bdrm_pkg::IDX_W-1:0]   in_index_lo,
  input  wire logic        [bdrm_pkg::IDX_W-1:0]   in_index_hi,
  input  wire logic signed [bdrm_pkg::VAL_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [bdrm_pkg::VAL_W-1:0]   out_range_min
);

  import bdrm_pkg::*;

  localparam int ADDR_W     = $clog2(NUM_ELEMENTS);
  localparam int NUM_BLOCKS = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OFF_W      = $clog2(BLOCK_SIZE);
  localparam int BS_W       = $clog2(BLOCK_SIZE + 1);
  localparam int RECIP      = (1 << ADDR_W) / BLOCK_SIZE;
  localparam int PROD_W     = 2 * ADDR_W;
  localparam int QB_W       = ADDR_W + BS_W;

  localparam logic [ADDR_W-1:0] RECIP_V = ADDR_W'(RECIP);
  localparam logic [31:0]       N_LAST  = 32'(NUM_ELEMENTS - 1);
  localparam logic [31:0]       BS_V    = 32'(BLOCK_SIZE);

  logic                    cmd_r;
  logic [IDX_W-1:0]        lo_raw_r;
  logic [IDX_W-1:0]        hi_raw_r;
  logic signed [VAL_W-1:0] val_r;

  logic              lo_ok;
  logic              hi_over;
  logic [ADDR_W-1:0] lo_a;
  logic [ADDR_W-1:0] hi_c;

  logic [ADDR_W-1:0] div_x;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [ADDR_W-1:0] q0;
  logic [QB_W-1:0]   qb;
  logic [ADDR_W-1:0] q0_r;
  logic [ADDR_W-1:0] r0_r;
  logic [ADDR_W-1:0] r0_nxt;
  logic              fix;
  logic [ADDR_W-1:0] q_fin;
  logic [ADDR_W-1:0] r_fin;
  logic [BLK_W-1:0]  qlo_r;
  logic [BLK_W-1:0]  qhi_r;
  logic [OFF_W-1:0]  rlo_r;
  logic [OFF_W-1:0]  rhi_r;

  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W-1:0] ptr_nxt;
  logic [ADDR_W-1:0] stop_r;
  logic [ADDR_W-1:0] stop_nxt;
  logic [31:0]       t_first;
  logic [31:0]       t_last;

  logic              rv_e_r;
  logic              rv_b_r;
  logic signed [VAL_W-1:0] acc_r;
  logic signed [VAL_W-1:0] acc_nxt;
  logic signed [VAL_W-1:0] e_rdata;
  logic signed [VAL_W-1:0] b_rdata;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic signed [VAL_W-1:0] out_min_r;

  logic              e_we;
  logic [ADDR_W-1:0] e_waddr;
  logic [VAL_W-1:0]  e_wdata;
  logic              b_we;
  logic [BLK_W-1:0]  b_waddr;
  logic [VAL_W-1:0]  b_wdata;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_cmd;
      lo_raw_r <= in_index_lo;
      hi_raw_r <= in_index_hi;
      val_r    <= in_value;
    end
  end

  assign lo_ok   = 32'(lo_raw_r) < 32'(NUM_ELEMENTS);
  assign hi_over = 32'(hi_raw_r) > N_LAST;
  assign lo_a    = ADDR_W'(32'(lo_raw_r));
  assign hi_c    = hi_over ? ADDR_W'(N_LAST) : ADDR_W'(32'(hi_raw_r));

  // Division by the block size: reciprocal multiply, then one correction step.
  assign div_x    = cmd.div_sel ? hi_c : lo_a;
  assign prod_nxt = PROD_W'(div_x) * PROD_W'(RECIP_V);
  assign q0       = prod_r[PROD_W-1:ADDR_W];
  assign qb       = QB_W'(q0) * QB_W'(BLOCK_SIZE);
  assign r0_nxt   = div_x - qb[ADDR_W-1:0];
  assign fix      = 32'(r0_r) >= BS_V;
  assign q_fin    = q0_r + ADDR_W'(fix);
  assign r_fin    = fix ? ADDR_W'(32'(r0_r) - BS_V) : r0_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q0_r   <= q0;
    r0_r   <= r0_nxt;
    if (cmd.div_ld_lo) begin
      qlo_r <= BLK_W'(q_fin);
      rlo_r <= OFF_W'(r_fin);
    end
    if (cmd.div_ld_hi) begin
      qhi_r <= BLK_W'(q_fin);
      rhi_r <= OFF_W'(r_fin);
    end
  end

  always_comb begin
    t_first  = '0;
    t_last   = '0;
    ptr_nxt  = ptr_r;
    stop_nxt = stop_r;
    case (cmd.ld)
      LD_WBLK: begin
        t_first  = 32'(lo_a) - 32'(rlo_r);
        t_last   = t_first + BS_V - 32'd1;
        ptr_nxt  = ADDR_W'(t_first);
        stop_nxt = (t_last > N_LAST) ? ADDR_W'(N_LAST) : ADDR_W'(t_last);
      end
      LD_A: begin
        t_last   = 32'(lo_a) + BS_V - 32'd1 - 32'(rlo_r);
        ptr_nxt  = lo_a;
        stop_nxt = (qlo_r == qhi_r) ? hi_c : ADDR_W'(t_last);
      end
      LD_B: begin
        ptr_nxt  = ADDR_W'(32'(qlo_r) + 32'd1);
        stop_nxt = ADDR_W'(32'(qhi_r) - 32'd1);
      end
      LD_C: begin
        ptr_nxt  = ADDR_W'(32'(hi_c) - 32'(rhi_r));
        stop_nxt = hi_c;
      end
      LD_NONE: begin
        if (cmd.clear || cmd.rd_elem || cmd.rd_blk) begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
    stop_r <= stop_nxt;
  end

  assign e_we    = cmd.elem_we;
  assign e_waddr = cmd.clear ? ptr_r : lo_a;
  assign e_wdata = cmd.clear ? INT_MAX : val_r;
  assign b_we    = cmd.blk_we && (!cmd.clear || (32'(ptr_r) < 32'(NUM_BLOCKS)));
  assign b_waddr = cmd.clear ? ptr_r[BLK_W-1:0] : qlo_r;
  assign b_wdata = cmd.clear ? INT_MAX : acc_r;

  bdrm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NUM_ELEMENTS)
  ) u_elem_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(ptr_r),
    .rdata(e_rdata)
  );

  bdrm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NUM_BLOCKS)
  ) u_blk_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(ptr_r[BLK_W-1:0]),
    .rdata(b_rdata)
  );

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.accept) begin
      acc_nxt = INT_MAX;
    end else if (rv_e_r && (e_rdata < acc_r)) begin
      acc_nxt = e_rdata;
    end else if (rv_b_r && (b_rdata < acc_r)) begin
      acc_nxt = b_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_e_r <= 1'b0;
      rv_b_r <= 1'b0;
    end else begin
      rv_e_r <= cmd.rd_elem;
      rv_b_r <= cmd.rd_blk;
    end
    acc_r <= acc_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_load) begin
      out_min_r <= acc_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_range_min = out_min_r;

  assign status.is_query     = (cmd_r == CMD_QUERY);
  assign status.lo_ok        = lo_ok;
  assign status.empty        = !lo_ok || (lo_a > hi_c);
  assign status.same_blk     = (qlo_r == qhi_r);
  assign status.mid_nonempty = (32'(qlo_r) + 32'd1) < 32'(qhi_r);
  assign status.scan_last    = (ptr_r == stop_r);
  assign status.clr_last     = (32'(ptr_r) == N_LAST);
  assign status.out_free     = !out_valid_r || out_ready;

`ifndef NO_ASSERTIONS
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(rv_e_r && rv_b_r))
    else $error("Element and block reads returned in the same cycle.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_elem || cmd.rd_blk) |-> (ptr_r <= stop_r))
    else $error("Scan pointer ran past the end of its range.");

  a_blk_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_blk |-> (32'(ptr_r) < 32'(NUM_BLOCKS)))
    else $error("Block minimum read beyond the last block.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("Result loaded over one that was not yet transferred.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bdrm_ctrl.sv
// Controller state machine that sequences clearing, writes, block rebuilds and range queries.
`default_nettype none

module bdrm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bdrm_pkg::dp_status_t status,
  output bdrm_pkg::ctl_cmd_t        cmd
);

  import bdrm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.ld    = LD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear   = 1'b1;
        cmd.elem_we = 1'b1;
        cmd.blk_we  = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.is_query) begin
          state_nxt = status.empty ? ST_RESULT : ST_DL1;
        end else begin
          state_nxt = status.lo_ok ? ST_DL1 : ST_IDLE;
        end
      end
      ST_DL1: begin
        state_nxt = ST_DL2;
      end
      ST_DL2: begin
        state_nxt = ST_DL3;
      end
      ST_DL3: begin
        cmd.div_ld_lo = 1'b1;
        state_nxt     = status.is_query ? ST_DH1 : ST_WR_ELEM;
      end
      ST_DH1: begin
        cmd.div_sel = 1'b1;
        state_nxt   = ST_DH2;
      end
      ST_DH2: begin
        cmd.div_sel = 1'b1;
        state_nxt   = ST_DH3;
      end
      ST_DH3: begin
        cmd.div_sel   = 1'b1;
        cmd.div_ld_hi = 1'b1;
        state_nxt     = ST_SET_A;
      end
      ST_WR_ELEM: begin
        cmd.elem_we = 1'b1;
        cmd.ld      = LD_WBLK;
        state_nxt   = ST_SCAN_A;
      end
      ST_SET_A: begin
        cmd.ld    = LD_A;
        state_nxt = ST_SCAN_A;
      end
      ST_SCAN_A: begin
        cmd.rd_elem = 1'b1;
        if (status.scan_last) begin
          if (!status.is_query || status.same_blk) begin
            state_nxt = ST_DRAIN;
          end else if (status.mid_nonempty) begin
            state_nxt = ST_SET_B;
          end else begin
            state_nxt = ST_SET_C;
          end
        end
      end
      ST_SET_B: begin
        cmd.ld    = LD_B;
        state_nxt = ST_SCAN_B;
      end
      ST_SCAN_B: begin
        cmd.rd_blk = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_SET_C;
        end
      end
      ST_SET_C: begin
        cmd.ld    = LD_C;
        state_nxt = ST_SCAN_C;
      end
      ST_SCAN_C: begin
        cmd.rd_elem = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = status.is_query ? ST_RESULT : ST_WR_BLK;
      end
      ST_WR_BLK: begin
        cmd.blk_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/block_decomposed_range_min.sv
// Top level of the block-decomposed range minimum unit.
`default_nettype none

// The unit holds NUM_ELEMENTS signed 32-bit elements in blocks of BLOCK_SIZE, each block with
// a stored minimum, and works on one item at a time. After reset a clearing pass sets every
// element and block minimum to the largest signed value; no item is taken during it. In a
// write the element is stored, then its block is read back one element a cycle to rebuild the
// block minimum. A query reads the two ragged ends through the single read port of the element
// memory and the whole blocks between them through that of the block-minimum memory. Empty
// queries go straight to the result, and writes beyond the array are dropped without a scan.
// A finished result waits in an output register, and the next item is taken meanwhile.

module block_decomposed_range_min #(
  parameter int NUM_ELEMENTS = bdrm_pkg::DEF_NUM_ELEMENTS,
  parameter int BLOCK_SIZE   = bdrm_pkg::DEF_BLOCK_SIZE
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic        [bdrm_pkg::IDX_W-1:0] in_index_lo,
  input  wire logic        [bdrm_pkg::IDX_W-1:0] in_index_hi,
  input  wire logic signed [bdrm_pkg::VAL_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed      [bdrm_pkg::VAL_W-1:0] out_range_min
);

  import bdrm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  bdrm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  bdrm_dp #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_cmd       (in_cmd),
    .in_index_lo  (in_index_lo),
    .in_index_hi  (in_index_hi),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_range_min(out_range_min)
  );

endmodule

`default_nettype wire
